>>> rtl/assert_macros.svh
// Assertion macros shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication or plain property, checked on the rising clock, off during reset.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);

// Condition that must never hold outside reset.
`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
    `ASSERT_CLK(label, clk, rst_n, !(cond), msg)

`endif

>>> rtl/pstk_pkg.sv
// Shared opcodes, status codes and controller/datapath interface types.
package pstk_pkg;

    typedef logic [1:0] t_opcode;
    localparam t_opcode OP_QUERY = 2'd0;
    localparam t_opcode OP_PUSH  = 2'd1;
    localparam t_opcode OP_POP   = 2'd2;

    typedef logic [1:0] t_status;
    localparam t_status ST_OK        = 2'd0;
    localparam t_status ST_POP_EMPTY = 2'd1;
    localparam t_status ST_PUSH_FULL = 2'd2;

    // controller -> datapath
    typedef struct packed {
        logic load;   // capture push value and priority
        logic push;   // sorted insert of captured element
        logic pop;    // remove front entry
    } t_dp_cmd;

    // datapath -> controller
    typedef struct packed {
        logic full;
        logic empty;
    } t_dp_stat;

endpackage

>>> rtl/pstk_dp.sv
// Datapath: sorted slot registers with parallel insert/remove shifting.
module pstk_dp
    import pstk_pkg::*;
#(
    parameter int CAPACITY      = 16,
    parameter int VALUE_BITS    = 32,
    parameter int PRIORITY_BITS = 8,
    parameter int CW            = $clog2(CAPACITY + 1)
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_dp_cmd                  i_cmd,
    input  logic [VALUE_BITS-1:0]    i_push_value,
    input  logic [PRIORITY_BITS-1:0] i_push_priority,
    output t_dp_stat                 o_stat,
    output logic [VALUE_BITS-1:0]    o_front_value,
    output logic [PRIORITY_BITS-1:0] o_front_priority,
    output logic [CW-1:0]            o_count
);

    logic [VALUE_BITS-1:0]    r_req_val;
    logic [PRIORITY_BITS-1:0] r_req_pri;
    logic [VALUE_BITS-1:0]    r_slot_val [CAPACITY];
    logic [PRIORITY_BITS-1:0] r_slot_pri [CAPACITY];
    logic [VALUE_BITS-1:0]    n_slot_val [CAPACITY];
    logic [PRIORITY_BITS-1:0] n_slot_pri [CAPACITY];
    logic [CW-1:0]            r_count;
    logic [CW-1:0]            n_count;
    logic [CAPACITY-1:0]      w_le;   // valid slot with priority <= new one

    // Slots are sorted descending, so w_le is a suffix of the valid range.
    always_comb begin
        for (int k = 0; k < CAPACITY; k++) begin
            w_le[k] = (CW'(k) < r_count) && (r_slot_pri[k] <= r_req_pri);
        end
    end

    always_comb begin
        n_count = r_count;
        for (int k = 0; k < CAPACITY; k++) begin
            n_slot_val[k] = r_slot_val[k];
            n_slot_pri[k] = r_slot_pri[k];
        end
        if (i_cmd.push) begin
            n_count = r_count + CW'(1);
            for (int k = 0; k < CAPACITY; k++) begin
                if (k > 0 && w_le[(k > 0) ? k - 1 : 0]) begin
                    n_slot_val[k] = r_slot_val[(k > 0) ? k - 1 : 0];
                    n_slot_pri[k] = r_slot_pri[(k > 0) ? k - 1 : 0];
                end else if (w_le[k] || CW'(k) == r_count) begin
                    n_slot_val[k] = r_req_val;
                    n_slot_pri[k] = r_req_pri;
                end
            end
        end else if (i_cmd.pop) begin
            n_count = r_count - CW'(1);
            for (int k = 0; k < CAPACITY - 1; k++) begin
                n_slot_val[k] = r_slot_val[k + 1];
                n_slot_pri[k] = r_slot_pri[k + 1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_req_val <= i_push_value;
            r_req_pri <= i_push_priority;
        end
        for (int k = 0; k < CAPACITY; k++) begin
            r_slot_val[k] <= n_slot_val[k];
            r_slot_pri[k] <= n_slot_pri[k];
        end
    end

    assign o_stat.full       = (r_count == CW'(CAPACITY));
    assign o_stat.empty      = (r_count == '0);
    assign o_count           = r_count;
    assign o_front_value     = o_stat.empty ? '0 : r_slot_val[0];
    assign o_front_priority  = o_stat.empty ? '0 : r_slot_pri[0];

endmodule

>>> rtl/pstk_ctrl.sv
// Controller: request sequencing, error checks and result strobe.
module pstk_ctrl
    import pstk_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_start,
    input  t_opcode  i_opcode,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd,
    output logic     o_busy,
    output logic     o_done,
    output t_status  o_status
);

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } t_state;

    t_state  r_state;
    t_opcode r_op;
    logic    r_done;
    t_status r_status;
    logic    w_accept;
    t_status w_status;

    assign w_accept = i_start && (r_state == S_IDLE);

    always_comb begin
        w_status = ST_OK;
        if (r_op == OP_PUSH && i_stat.full) begin
            w_status = ST_PUSH_FULL;
        end else if (r_op == OP_POP && i_stat.empty) begin
            w_status = ST_POP_EMPTY;
        end
    end

    always_comb begin
        o_cmd.load = w_accept;
        o_cmd.push = (r_state == S_EXEC) && (r_op == OP_PUSH) && !i_stat.full;
        o_cmd.pop  = (r_state == S_EXEC) && (r_op == OP_POP) && !i_stat.empty;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_done   <= 1'b0;
            r_status <= ST_OK;
            r_op     <= OP_QUERY;
        end else begin
            r_done <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_op    <= i_opcode;
                        r_state <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    r_status <= w_status;
                    r_done   <= 1'b1;
                    r_state  <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_busy   = (r_state == S_EXEC);
    assign o_done   = r_done;
    assign o_status = r_status;

endmodule

>>> rtl/priority_stack.sv
// Top level of the bounded priority stack: controller plus slot datapath.
//
// Bounded priority stack of CAPACITY entries. Each request (query, push or
// pop) is taken on a rising edge with start high and busy low, and
// returns exactly one result beat, flagged by o_done for a single cycle;
// the receiver cannot stall, so sample it then. No new request is taken
// while busy: the idle state captures the request, the execute state
// applies it to the slot registers, where every slot compares its priority
// with the new one in parallel and shifts in one step. A new request may be
// presented in the same cycle that o_done is high. A push goes ahead of all
// entries of lower or equal priority (equal priorities leave last-in
// first-out). A pop on an empty stack or a push on a full one changes nothing
// and reports status 1 or 2. The front value and priority read zero when
// the stack is empty. No clearing pass: the stack is ready right after reset.
module priority_stack
    import pstk_pkg::*;
#(
    parameter int CAPACITY      = 16,
    parameter int VALUE_BITS    = 32,
    parameter int PRIORITY_BITS = 8
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic [1:0]                         i_opcode,
    input  logic [VALUE_BITS-1:0]              i_push_value,
    input  logic [PRIORITY_BITS-1:0]           i_push_priority,
    output logic                               o_done,
    output logic [VALUE_BITS-1:0]              o_front_value,
    output logic [PRIORITY_BITS-1:0]           o_front_priority,
    output logic [$clog2(CAPACITY + 1)-1:0]    o_entry_count,
    output logic                               o_is_empty,
    output logic [1:0]                         o_status
);

`include "assert_macros.svh"

    localparam int CW = $clog2(CAPACITY + 1);

    t_dp_cmd  w_cmd;
    t_dp_stat w_stat;

    pstk_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_opcode (i_opcode),
        .i_stat   (w_stat),
        .o_cmd    (w_cmd),
        .o_busy   (busy),
        .o_done   (o_done),
        .o_status (o_status)
    );

    pstk_dp #(
        .CAPACITY      (CAPACITY),
        .VALUE_BITS    (VALUE_BITS),
        .PRIORITY_BITS (PRIORITY_BITS),
        .CW            (CW)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (w_cmd),
        .i_push_value     (i_push_value),
        .i_push_priority  (i_push_priority),
        .o_stat           (w_stat),
        .o_front_value    (o_front_value),
        .o_front_priority (o_front_priority),
        .o_count          (o_entry_count)
    );

    // Empty flag mirrors the count.
    assign o_is_empty = w_stat.empty;

    // Accepted request always occupies the execute cycle next.
    `ASSERT_CLK(a_accept_busy, i_clk, i_rst_n, (start && !busy) |=> busy, "accept without exec")
    // Execute is followed by the result beat, with the block idle again.
    `ASSERT_CLK(a_exec_done, i_clk, i_rst_n, busy |=> (o_done && !busy), "exec not followed by beat")
    // Count stays within capacity.
    `ASSERT_NEVER(a_count_max, i_clk, i_rst_n, o_entry_count > CW'(CAPACITY), "count overflow")
    // Rejected request leaves the count unchanged.
    `ASSERT_CLK(a_reject_hold, i_clk, i_rst_n, (o_done && o_status != ST_OK) |-> $stable(o_entry_count), "error changed count")

endmodule

>>> dv/priority_stack_checker.sv
// Checker for priority_stack: tracks accepted requests, predicts each result beat and compares.
module priority_stack_checker
    import pstk_pkg::*;
#(
    parameter int DEPTH = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    input  logic        busy,
    input  logic [1:0]  i_opcode,
    input  logic [31:0] i_push_value,
    input  logic [7:0]  i_push_priority,
    input  logic        o_done,
    input  logic [31:0] o_front_value,
    input  logic [7:0]  o_front_priority,
    input  logic [4:0]  o_entry_count,
    input  logic        o_is_empty,
    input  logic [1:0]  o_status,
    output int          o_error_count,
    output int          o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [31:0] value;
        logic [7:0]  prio;
        logic [4:0]  count;
        logic        empty;
        t_status     status;
    } t_front_report;

    // shadow copy of the stack, slot 0 is the front
    logic [31:0]   held_value    [DEPTH];
    logic [7:0]    held_priority [DEPTH];
    int            held_count;
    t_front_report expected_reports [$];
    int            errs;

    initial begin
        o_error_count = 0;
        o_pending     = 0;
        errs          = 0;
        held_count    = 0;
    end

    // sorted insert ahead of lower-or-equal priorities, pop from the front
    function automatic t_front_report apply_request(t_opcode op, logic [31:0] val,
                                                    logic [7:0] prio);
        t_front_report r;
        int            pos;
        int            k;
        r.status = ST_OK;
        case (op)
            OP_PUSH: begin
                if (held_count >= DEPTH) begin
                    r.status = ST_PUSH_FULL;
                end else begin
                    pos = 0;
                    while (pos < held_count && held_priority[pos] > prio) pos++;
                    for (k = held_count; k > pos; k--) begin
                        held_value[k]    = held_value[k-1];
                        held_priority[k] = held_priority[k-1];
                    end
                    held_value[pos]    = val;
                    held_priority[pos] = prio;
                    held_count++;
                end
            end
            OP_POP: begin
                if (held_count == 0) begin
                    r.status = ST_POP_EMPTY;
                end else begin
                    for (k = 1; k < held_count; k++) begin
                        held_value[k-1]    = held_value[k];
                        held_priority[k-1] = held_priority[k];
                    end
                    held_count--;
                end
            end
            default: ;  // query, and the spare code behaves as one
        endcase
        r.empty = (held_count == 0);
        r.value = r.empty ? 32'd0 : held_value[0];
        r.prio  = r.empty ? 8'd0 : held_priority[0];
        r.count = 5'(held_count);
        return r;
    endfunction

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch: expected %h, got %h", $time, name, want, got);
            errs++;
        end
    endfunction

    always @(posedge i_clk) begin
        t_front_report want;
        if (!i_rst_n) begin
            held_count = 0;
            expected_reports.delete();
        end else begin
            if (o_done) begin
                if (expected_reports.size() == 0) begin
                    $display("%0t: unexpected result beat, expected none, got value %h count %0d",
                             $time, o_front_value, o_entry_count);
                    errs++;
                end else begin
                    want = expected_reports.pop_front();
                    check_field("front_value", want.value, o_front_value);
                    check_field("front_priority", 32'(want.prio), 32'(o_front_priority));
                    check_field("entry_count", 32'(want.count), 32'(o_entry_count));
                    check_field("is_empty", 32'(want.empty), 32'(o_is_empty));
                    check_field("status", 32'(want.status), 32'(o_status));
                end
            end
            if (start && !busy) begin
                expected_reports.push_back(apply_request(i_opcode, i_push_value,
                                                         i_push_priority));
            end
        end
        o_error_count <= errs;
        o_pending     <= expected_reports.size();
    end

endmodule

>>> dv/priority_stack_tb.sv
// Testbench top for priority_stack: clock, reset, request stimulus and verdict.
module priority_stack_tb
    import pstk_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    // spare opcode value, the block treats it as a query
    localparam t_opcode OP_RSVD = 2'd3;
    localparam int LIMIT_CYCLES = 100000;
    localparam int PHASE_ITEMS  = 430;

    logic        i_clk           = 1'b0;
    logic        i_rst_n         = 1'b0;
    logic        start           = 1'b0;
    logic        busy;
    logic [1:0]  i_opcode        = OP_QUERY;
    logic [31:0] i_push_value    = '0;
    logic [7:0]  i_push_priority = '0;
    logic        o_done;
    logic [31:0] o_front_value;
    logic [7:0]  o_front_priority;
    logic [4:0]  o_entry_count;
    logic        o_is_empty;
    logic [1:0]  o_status;

    int error_count;
    int pending;
    int cycle_count = 0;
    int idle_pct    = 13;   // chance in 100, checked again after each idle, that the sender holds back

    always #5 i_clk = ~i_clk;

    priority_stack uut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .start            (start),
        .busy             (busy),
        .i_opcode         (i_opcode),
        .i_push_value     (i_push_value),
        .i_push_priority  (i_push_priority),
        .o_done           (o_done),
        .o_front_value    (o_front_value),
        .o_front_priority (o_front_priority),
        .o_entry_count    (o_entry_count),
        .o_is_empty       (o_is_empty),
        .o_status         (o_status)
    );

    priority_stack_checker chk (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .start            (start),
        .busy             (busy),
        .i_opcode         (i_opcode),
        .i_push_value     (i_push_value),
        .i_push_priority  (i_push_priority),
        .o_done           (o_done),
        .o_front_value    (o_front_value),
        .o_front_priority (o_front_priority),
        .o_entry_count    (o_entry_count),
        .o_is_empty       (o_is_empty),
        .o_status         (o_status),
        .o_error_count    (error_count),
        .o_pending        (pending)
    );

    // Watchdog: a hung handshake or a lost result beat ends up here.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("priority_stack_tb: errors");
            $finish;
        end
    end

    // One request beat. Random idle cycles go in front of it; start then
    // stays high until an edge sees busy low. Only one assignment to start
    // is made per edge, so back-to-back beats keep start high throughout.
    task automatic issue(t_opcode op, logic [31:0] val, logic [7:0] prio);
        while ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start           <= 1'b1;
        i_opcode        <= op;
        i_push_value    <= val;
        i_push_priority <= prio;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
    endtask

    initial begin
        int       mode;
        int       roll;
        t_opcode  op;
        logic [7:0] prio;

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // --- directed: empty store, ties at both ends, fill to capacity ---
        issue(OP_QUERY, $urandom, 8'($urandom));        // query on empty
        issue(OP_POP, $urandom, 8'($urandom));          // pop on empty, ignored
        issue(OP_RSVD, 32'hFFFF_FFFF, 8'hFF);           // spare code acts as query
        issue(OP_PUSH, 32'hFFFF_FFFF, 8'hFF);
        issue(OP_PUSH, 32'h0000_0000, 8'h00);
        issue(OP_PUSH, 32'hA5A5_A5A5, 8'hFF);           // tie at top goes in front
        issue(OP_PUSH, 32'h5A5A_5A5A, 8'h00);           // tie at bottom, ahead of older 0
        for (int k = 1; k <= 12; k++) begin
            issue(OP_PUSH, $urandom, 8'(k * 20));       // mid priorities, now full
        end
        issue(OP_PUSH, $urandom, 8'h80);                // push on full, ignored
        issue(OP_RSVD, $urandom, 8'($urandom));

        // --- random: three idle profiles, ops biased in 40-beat stretches so
        //     the count sweeps between empty and full ---
        for (int phase = 0; phase < 3; phase++) begin
            idle_pct = (phase == 0) ? 13 : (phase == 1) ? 59 : 0;
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (n % 40 == 0) mode = $urandom_range(2);
                roll = $urandom_range(99);
                case (mode)
                    0:       op = (roll < 70) ? OP_PUSH : (roll < 90) ? OP_POP :
                                  (roll < 97) ? OP_QUERY : OP_RSVD;
                    1:       op = (roll < 20) ? OP_PUSH : (roll < 90) ? OP_POP :
                                  (roll < 97) ? OP_QUERY : OP_RSVD;
                    default: op = (roll < 45) ? OP_PUSH : (roll < 90) ? OP_POP :
                                  (roll < 96) ? OP_QUERY : OP_RSVD;
                endcase
                // narrow and extreme priorities make ties common
                case ($urandom_range(3))
                    0:       prio = 8'($urandom_range(3));
                    1:       prio = $urandom_range(1) ? 8'hFF : 8'h00;
                    default: prio = 8'($urandom);
                endcase
                issue(op, $urandom, prio);
            end
        end
        start <= 1'b0;

        // drain: every accepted beat must come back, then a short tail
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);

        if (error_count == 0) begin
            $display("priority_stack_tb: clean");
        end else begin
            $display("priority_stack_tb: errors");
        end
        $finish;
    end

endmodule
